// ===== design/bfsb_pkg.sv =====
// Shared types and constants of the bit field stream buffer.
package bfsb_pkg;

   localparam int CMD_W      = 2;
   localparam int DATA_W     = 56;
   localparam int NUM_W      = 6;
   localparam int POS_W      = 15;
   localparam int SIZE_W     = 16;
   localparam int CFG_W      = 13;
   localparam int WORD_W     = 64;
   localparam int OFS_W      = 6;

   localparam int MAX_FIELD_BITS = 56;
   localparam int ALLOC_RESET    = 4096;

   localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RSVD   = 2'd3;

   typedef struct packed {
      logic clear;
      logic accept;
      logic exec;
   } bfsb_cmd_type;

   typedef struct packed {
      logic clear_done;
   } bfsb_sts_type;

endpackage

// ===== design/bfsb_ctrl.sv =====
// Controller state machine: store clearing, idle and execute phases.
module bfsb_ctrl
   import bfsb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  bfsb_sts_type sts,
   output bfsb_cmd_type cmd,
   output logic         busy,
   output logic         rsp_strobe
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       strobe_ff, strobe_in;

   always_comb begin
      cmd.clear  = (state_ff == ST_CLEAR);
      cmd.accept = (state_ff == ST_IDLE) && start;
      cmd.exec   = (state_ff == ST_EXEC);
      busy       = (state_ff != ST_IDLE);
      rsp_strobe = strobe_ff;
      strobe_in  = cmd.exec;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

endmodule

// ===== design/bfsb_dp.sv =====
// Datapath: request decode, two-bank word store, field insert and extract.
module bfsb_dp
   import bfsb_pkg::*;
#(
   parameter int STORE_BYTES = 4096
)(
   input  logic              clock,
   input  logic              reset,
   input  bfsb_cmd_type      cmd,
   output bfsb_sts_type      sts,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [DATA_W-1:0] req_bits,
   input  logic [NUM_W-1:0]  req_num_bits,
   input  logic [POS_W-1:0]  req_position,
   input  logic              csr_wr,
   input  logic [CFG_W-1:0]  csr_data,
   output logic [NUM_W-1:0]  rsp_count,
   output logic [DATA_W-1:0] rsp_read_bits,
   output logic [SIZE_W-1:0] rsp_size_bits,
   output logic              rsp_error
);

   localparam int WORDS      = (STORE_BYTES + 7) / 8;
   localparam int HALF_WORDS = (WORDS + 1) / 2;
   localparam int BANK_DEPTH = (HALF_WORDS < 2) ? 2 : HALF_WORDS;
   localparam int ROW_W      = $clog2(BANK_DEPTH);
   localparam int IDX_W      = SIZE_W - OFS_W;
   localparam int ALLOC_INIT = (ALLOC_RESET < STORE_BYTES) ? ALLOC_RESET : STORE_BYTES;
   localparam logic [SIZE_W-1:0] MAX_POS_RESET = SIZE_W'(ALLOC_INIT * 8);
   localparam logic [16:0]       STORE_LIM     = 17'(STORE_BYTES);
   localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(BANK_DEPTH - 1);

   // Two banks of 64-bit words: even words in one, odd words in the other,
   // so the two words a field can span are read and written together.
   logic [WORD_W-1:0] even_mem [BANK_DEPTH];
   logic [WORD_W-1:0] odd_mem  [BANK_DEPTH];
   logic [WORD_W-1:0] even_q_ff, odd_q_ff;

   logic [ROW_W-1:0]  clr_row_ff, clr_row_in;
   logic [SIZE_W-1:0] max_pos_ff, max_pos_in;
   logic [SIZE_W-1:0] ws_ff, ws_in;

   // Decoded request, held from accept through execute.
   logic              op_err_ff, op_read_ff, op_lo_odd_ff;
   logic [NUM_W-1:0]  op_cnt_ff;
   logic [OFS_W-1:0]  op_ofs_ff;
   logic [SIZE_W-1:0] op_end_ff;
   logic [DATA_W-1:0] op_data_ff, op_mask_ff;
   logic [ROW_W-1:0]  op_even_row_ff, op_odd_row_ff;

   logic [NUM_W-1:0]  rsp_count_ff;
   logic [DATA_W-1:0] rsp_read_bits_ff;
   logic [SIZE_W-1:0] rsp_size_ff;
   logic              rsp_error_ff;

   // Accept-side decode.
   logic              bad_req, dec_read, dec_err;
   logic [SIZE_W-1:0] dec_pos, dec_limit, dec_room, dec_end;
   logic [NUM_W-1:0]  dec_cnt;
   logic [DATA_W-1:0] dec_mask;
   logic [IDX_W-1:0]  dec_word;
   logic [IDX_W:0]    dec_word_inc;
   logic [ROW_W-1:0]  dec_even_row, dec_odd_row;
   logic [CFG_W-1:0]  alloc_clip;

   // Execute-side insert and extract.
   logic [2*WORD_W-1:0] old_dw, data_sh, mask_sh, new_dw;
   logic [2*WORD_W-1:0] ext_sh;
   logic [DATA_W-1:0]   ext_bits;
   logic                we_lo, we_hi, even_we, odd_we;
   logic [WORD_W-1:0]   even_wdata, odd_wdata;
   logic [ROW_W-1:0]    even_waddr, odd_waddr;

   always_comb begin
      bad_req  = (req_num_bits == '0) || (req_num_bits > NUM_W'(MAX_FIELD_BITS))
                 || (req_cmd == CMD_RSVD);
      dec_read = (req_cmd == CMD_READ);
      dec_pos  = (req_cmd == CMD_APPEND) ? ws_ff : {1'b0, req_position};
      // Reads stop at the written end, writes at the allocated end.
      dec_limit = dec_read ? ws_ff : max_pos_ff;
      dec_err   = bad_req || (dec_pos >= dec_limit);
      dec_room  = dec_limit - dec_pos;
      dec_cnt   = (dec_room < {{(SIZE_W-NUM_W){1'b0}}, req_num_bits}) ?
                  dec_room[NUM_W-1:0] : req_num_bits;
      if (dec_err) dec_cnt = '0;
      dec_end      = dec_pos + {{(SIZE_W-NUM_W){1'b0}}, dec_cnt};
      dec_mask     = ~({DATA_W{1'b1}} << dec_cnt);
      dec_word     = dec_pos[SIZE_W-1:OFS_W];
      dec_word_inc = {1'b0, dec_word} + (IDX_W+1)'(1);
      dec_even_row = ROW_W'(dec_word_inc >> 1);
      dec_odd_row  = ROW_W'(dec_word >> 1);
   end

   always_comb begin
      alloc_clip = ({4'b0, csr_data} > STORE_LIM) ? CFG_W'(STORE_BYTES) : csr_data;
      max_pos_in = csr_wr ? {alloc_clip, 3'b000} : max_pos_ff;
   end

   always_comb begin
      old_dw   = op_lo_odd_ff ? {even_q_ff, odd_q_ff} : {odd_q_ff, even_q_ff};
      ext_sh   = old_dw >> op_ofs_ff;
      ext_bits = ext_sh[DATA_W-1:0] & op_mask_ff;
      data_sh  = {{(2*WORD_W-DATA_W){1'b0}}, op_data_ff} << op_ofs_ff;
      mask_sh  = {{(2*WORD_W-DATA_W){1'b0}}, op_mask_ff} << op_ofs_ff;
      new_dw   = (old_dw & ~mask_sh) | data_sh;
      we_lo    = cmd.exec && !op_read_ff && (|mask_sh[WORD_W-1:0]);
      we_hi    = cmd.exec && !op_read_ff && (|mask_sh[2*WORD_W-1:WORD_W]);
      even_we    = cmd.clear || (op_lo_odd_ff ? we_hi : we_lo);
      odd_we     = cmd.clear || (op_lo_odd_ff ? we_lo : we_hi);
      even_wdata = cmd.clear ? '0 :
                   (op_lo_odd_ff ? new_dw[2*WORD_W-1:WORD_W] : new_dw[WORD_W-1:0]);
      odd_wdata  = cmd.clear ? '0 :
                   (op_lo_odd_ff ? new_dw[WORD_W-1:0] : new_dw[2*WORD_W-1:WORD_W]);
      even_waddr = cmd.clear ? clr_row_ff : op_even_row_ff;
      odd_waddr  = cmd.clear ? clr_row_ff : op_odd_row_ff;
   end

   always_comb begin
      ws_in = ws_ff;
      if (cmd.exec && !op_err_ff && !op_read_ff && (op_end_ff > ws_ff)) ws_in = op_end_ff;
      clr_row_in     = cmd.clear ? clr_row_ff + ROW_W'(1) : '0;
      sts.clear_done = cmd.clear && (clr_row_ff == LAST_ROW);
   end

   always_ff @(posedge clock) begin
      if (even_we) even_mem[even_waddr] <= even_wdata;
      if (cmd.accept) even_q_ff <= even_mem[dec_even_row];
   end

   always_ff @(posedge clock) begin
      if (odd_we) odd_mem[odd_waddr] <= odd_wdata;
      if (cmd.accept) odd_q_ff <= odd_mem[dec_odd_row];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_row_ff <= '0;
         max_pos_ff <= MAX_POS_RESET;
         ws_ff      <= '0;
      end else begin
         clr_row_ff <= clr_row_in;
         max_pos_ff <= max_pos_in;
         ws_ff      <= ws_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_err_ff      <= dec_err;
         op_read_ff     <= dec_read;
         op_lo_odd_ff   <= dec_word[0];
         op_cnt_ff      <= dec_cnt;
         op_ofs_ff      <= dec_pos[OFS_W-1:0];
         op_end_ff      <= dec_end;
         op_data_ff     <= req_bits & dec_mask;
         op_mask_ff     <= dec_mask;
         op_even_row_ff <= dec_even_row;
         op_odd_row_ff  <= dec_odd_row;
      end
      if (cmd.exec) begin
         rsp_count_ff     <= op_cnt_ff;
         rsp_read_bits_ff <= op_read_ff ? ext_bits : '0;
         rsp_size_ff      <= ws_in;
         rsp_error_ff     <= op_err_ff;
      end
   end

   assign rsp_count     = rsp_count_ff;
   assign rsp_read_bits = rsp_read_bits_ff;
   assign rsp_size_bits = rsp_size_ff;
   assign rsp_error     = rsp_error_ff;

endmodule

// ===== design/bit_field_stream_buffer_top.sv =====
// Top level of the bit field stream buffer: controller, datapath and checks.
//
// Usage:
// A transaction is accepted on the rising edge where start is high and busy
// is low; req_cmd selects write at req_position, append at the written end,
// or read at req_position, with req_num_bits bits (1 to 56) from req_bits.
// Each transaction gives one result, shown for exactly one cycle with
// rsp_strobe high: rsp_count, rsp_read_bits, rsp_size_bits and rsp_error.
// The accepting edge reads the two 64-bit store words the field spans into
// registers and moves the controller into execute, which merges or extracts
// the field, writes the words back and loads the result registers together
// with rsp_strobe. busy stays high in execute, so no new transaction is taken
// before the last is through. The receiver cannot stall the block.
// After reset the store is cleared one row of both word banks per cycle, over
// all BANK_DEPTH rows (256 at the default size), with busy held high.
// The csr_ channel writes the allocated byte count; csr_ready is always
// high, and writes are expected only while no transaction is in flight.
module bit_field_stream_buffer_top
   import bfsb_pkg::*;
#(
   parameter int STORE_BYTES = 4096
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [DATA_W-1:0] req_bits,
   input  logic [NUM_W-1:0]  req_num_bits,
   input  logic [POS_W-1:0]  req_position,
   output logic              rsp_strobe,
   output logic [NUM_W-1:0]  rsp_count,
   output logic [DATA_W-1:0] rsp_read_bits,
   output logic [SIZE_W-1:0] rsp_size_bits,
   output logic              rsp_error,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CFG_W-1:0]  csr_data
);

   bfsb_cmd_type ctrl_cmd;
   bfsb_sts_type dp_sts;

   assign csr_ready = 1'b1;

   bfsb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .sts        (dp_sts),
      .cmd        (ctrl_cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   bfsb_dp #(
      .STORE_BYTES (STORE_BYTES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (ctrl_cmd),
      .sts           (dp_sts),
      .req_cmd       (req_cmd),
      .req_bits      (req_bits),
      .req_num_bits  (req_num_bits),
      .req_position  (req_position),
      .csr_wr        (csr_valid && csr_ready),
      .csr_data      (csr_data),
      .rsp_count     (rsp_count),
      .rsp_read_bits (rsp_read_bits),
      .rsp_size_bits (rsp_size_bits),
      .rsp_error     (rsp_error)
   );

`ifndef NO_ASSERTIONS
   // Every accepted transaction yields its result strobe.
   a_accept_to_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("accepted transaction produced no result");

   // A rejected transaction reports nothing moved.
   a_error_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_error) |-> (rsp_count == '0 && rsp_read_bits == '0))
      else $error("error result carries a count or data");

   // A successful transaction always moves at least one bit.
   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_error) |-> (rsp_count != '0))
      else $error("successful result with zero count");

   // While executing, the controller holds busy high and neither accepts nor clears.
   a_busy_with_exec: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.exec |-> (busy && !ctrl_cmd.accept && !ctrl_cmd.clear))
      else $error("execute phase overlaps accept or clear");
`endif

endmodule
